[src/cic_pkg.sv]
// ----------------------------------------------------------------------------
// cic_pkg
// Types, codes and helpers shared by the cascaded interrupt controller files.
// ----------------------------------------------------------------------------
package cic_pkg;

    localparam int CHIP_COUNT = 2;

    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_RAISE = 3'd2;
    localparam logic [2:0] ACT_LOWER = 3'd3;
    localparam logic [2:0] ACT_CHECK = 3'd4;

    localparam logic [3:0] LINE_NONE = 4'h8;
    localparam logic [2:0] CASCADE_LINE = 3'd2;

    localparam logic [7:0] MASK_RESET_MASTER   = 8'hff;
    localparam logic [7:0] MASK_RESET_SLAVE    = 8'hfe;
    localparam logic [7:0] VECTOR_RESET_MASTER = 8'h08;
    localparam logic [7:0] VECTOR_RESET_SLAVE  = 8'h70;
    localparam logic [7:0] OCW3_RESET          = 8'h02;
    localparam logic [7:0] POLL_FLAG           = 8'h80;
    localparam logic [7:0] VECTOR_BASE_MASK    = 8'hf8;

    typedef enum logic [3:0] {
        PH_READY = 4'b0001,
        PH_ICW2  = 4'b0010,
        PH_ICW3  = 4'b0100,
        PH_ICW4  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] port_index;
        logic [7:0] write_data;
        logic [3:0] irq_line;
        logic       cpu_if;
        logic       block_all;
        logic       keep_request;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       taken;
        logic [7:0] vector;
        logic [3:0] taken_line;
        logic       irq_deferred;
    } result_t;

    // Highest-priority set bit when priority starts at start, else LINE_NONE.
    function automatic logic [3:0] first_line(logic [7:0] r, logic [2:0] start);
        logic [3:0] res;
        logic [2:0] idx;
        res = LINE_NONE;
        for (int k = 7; k >= 0; k--)
        begin
            idx = start + 3'(k);
            if (r[idx])
            begin
                res = {1'b0, idx};
            end
        end
        return res;
    endfunction

endpackage

[src/cic_in_stage.sv]
// ----------------------------------------------------------------------------
// cic_in_stage
// Input register: holds one accepted beat until the core consumes it.
// ----------------------------------------------------------------------------
module cic_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  cic_pkg::item_t item_in,
    input  logic          can_load,
    output logic          fire,
    output cic_pkg::item_t item_out
);

    logic           valid_reg;
    cic_pkg::item_t item_reg;

    assign fire       = valid_reg && can_load;
    assign item_stall = valid_reg && !can_load;
    assign item_out   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item_in;
        end
    end

endmodule

[src/cic_core.sv]
// ----------------------------------------------------------------------------
// cic_core
// Master and slave controller state with single-pass decode of one action.
// ----------------------------------------------------------------------------
module cic_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  cic_pkg::item_t   item,
    output cic_pkg::result_t result
);

    localparam int NC = cic_pkg::CHIP_COUNT;

    cic_pkg::phase_t phase_reg [NC];
    cic_pkg::phase_t phase_next [NC];
    logic [7:0] mask_reg [NC];
    logic [7:0] mask_next [NC];
    logic [7:0] vbase_reg [NC];
    logic [7:0] vbase_next [NC];
    logic [7:0] irr_reg [NC];
    logic [7:0] irr_next [NC];
    logic [7:0] isr_reg [NC];
    logic [7:0] isr_next [NC];
    logic [2:0] lps_reg [NC];
    logic [2:0] lps_next [NC];
    logic [7:0] ocw3_reg [NC];
    logic [7:0] ocw3_next [NC];
    logic [7:0] icw1_reg [NC];
    logic [7:0] icw1_next [NC];
    logic [7:0] icw3_reg [NC];
    logic [7:0] icw3_next [NC];
    logic [7:0] icw4_reg [NC];
    logic [7:0] icw4_next [NC];

    logic [3:0] req_hi [NC];
    logic [3:0] svc_hi [NC];
    logic       line_ok [NC];

    logic       sel;
    logic       any_req;
    logic [2:0] line;
    logic [7:0] bit_sel;
    logic       cascade_ok;
    logic       chip;
    logic [7:0] d;
    logic [2:0] n;
    logic [7:0] ibit;

    assign chip = item.port_index[1];
    assign d    = item.write_data;
    assign n    = item.write_data[2:0];
    assign ibit = 8'(1) << item.irq_line[2:0];

    always_comb
    begin
        logic [2:0] dl;
        logic [2:0] dh;
        for (int c = 0; c < NC; c++)
        begin
            req_hi[c] = cic_pkg::first_line(irr_reg[c], lps_reg[c]);
            svc_hi[c] = cic_pkg::first_line(isr_reg[c], lps_reg[c]);
            dl = req_hi[c][2:0] - lps_reg[c];
            dh = svc_hi[c][2:0] - lps_reg[c];
            line_ok[c] = !req_hi[c][3] && !mask_reg[c][req_hi[c][2:0]] && !ocw3_reg[c][2]
                         && (ocw3_reg[c][5] || svc_hi[c][3] || (dl < dh));
        end
    end

    assign any_req    = !req_hi[0][3] || !req_hi[1][3];
    assign sel        = req_hi[0][3];
    assign line       = sel ? req_hi[1][2:0] : req_hi[0][2:0];
    assign bit_sel    = 8'(1) << line;
    assign cascade_ok = !sel || !(mask_reg[0][cic_pkg::CASCADE_LINE]
                                  || isr_reg[0][cic_pkg::CASCADE_LINE]);

    always_comb
    begin
        result = '0;
        for (int c = 0; c < NC; c++)
        begin
            phase_next[c] = phase_reg[c];
            mask_next[c]  = mask_reg[c];
            vbase_next[c] = vbase_reg[c];
            irr_next[c]   = irr_reg[c];
            isr_next[c]   = isr_reg[c];
            lps_next[c]   = lps_reg[c];
            ocw3_next[c]  = ocw3_reg[c];
            icw1_next[c]  = icw1_reg[c];
            icw3_next[c]  = icw3_reg[c];
            icw4_next[c]  = icw4_reg[c];
        end
        unique case (item.action)
            cic_pkg::ACT_WRITE:
            begin
                for (int c = 0; c < NC; c++)
                begin
                    if (chip == 1'(c))
                    begin
                        if (!item.port_index[0])
                        begin
                            priority if (d[4])
                            begin
                                icw1_next[c]  = d;
                                phase_next[c] = cic_pkg::PH_ICW2;
                                ocw3_next[c]  = cic_pkg::OCW3_RESET;
                                lps_next[c]   = 3'd0;
                            end
                            else if (d[3])
                            begin
                                if (d[1])
                                begin
                                    ocw3_next[c][1:0] = d[1:0];
                                end
                                ocw3_next[c][2] = d[2];
                                if (d[6])
                                begin
                                    ocw3_next[c][6:5] = d[6:5];
                                end
                            end
                            else if (d[5] && !d[6])
                            begin
                                if (!svc_hi[c][3])
                                begin
                                    isr_next[c][svc_hi[c][2:0]] = 1'b0;
                                    if (d[7])
                                    begin
                                        lps_next[c] = svc_hi[c][2:0] + 3'd1;
                                    end
                                end
                            end
                            else
                            begin
                                if (d[5])
                                begin
                                    isr_next[c][n] = 1'b0;
                                end
                                if (d[7] && d[6])
                                begin
                                    lps_next[c] = n + 3'd1;
                                end
                            end
                        end
                        else
                        begin
                            unique case (phase_reg[c])
                                cic_pkg::PH_ICW2:
                                begin
                                    vbase_next[c] = d;
                                    if (icw1_reg[c][1])
                                    begin
                                        phase_next[c] = icw1_reg[c][0] ? cic_pkg::PH_ICW4
                                                                       : cic_pkg::PH_READY;
                                    end
                                    else
                                    begin
                                        phase_next[c] = cic_pkg::PH_ICW3;
                                    end
                                end
                                cic_pkg::PH_ICW3:
                                begin
                                    icw3_next[c]  = d;
                                    phase_next[c] = icw1_reg[c][0] ? cic_pkg::PH_ICW4
                                                                   : cic_pkg::PH_READY;
                                end
                                cic_pkg::PH_ICW4:
                                begin
                                    icw4_next[c]  = d;
                                    phase_next[c] = cic_pkg::PH_READY;
                                end
                                default:
                                begin
                                    mask_next[c] = d;
                                end
                            endcase
                        end
                    end
                end
            end
            cic_pkg::ACT_READ:
            begin
                for (int c = 0; c < NC; c++)
                begin
                    if (chip == 1'(c))
                    begin
                        if (item.port_index[0])
                        begin
                            result.read_data = mask_reg[c];
                        end
                        else if (ocw3_reg[c][2])
                        begin
                            ocw3_next[c][2] = 1'b0;
                            if (!req_hi[c][3])
                            begin
                                irr_next[c][req_hi[c][2:0]] = 1'b0;
                                isr_next[c][req_hi[c][2:0]] = 1'b1;
                                result.read_data = cic_pkg::POLL_FLAG | {5'd0, req_hi[c][2:0]};
                            end
                        end
                        else
                        begin
                            result.read_data = ocw3_reg[c][0] ? isr_reg[c] : irr_reg[c];
                        end
                    end
                end
            end
            cic_pkg::ACT_RAISE:
            begin
                for (int c = 0; c < NC; c++)
                begin
                    if (item.irq_line[3] == 1'(c))
                    begin
                        irr_next[c] = irr_reg[c] | ibit;
                    end
                end
            end
            cic_pkg::ACT_LOWER:
            begin
                for (int c = 0; c < NC; c++)
                begin
                    if (item.irq_line[3] == 1'(c))
                    begin
                        irr_next[c] = irr_reg[c] & ~ibit;
                    end
                end
            end
            cic_pkg::ACT_CHECK:
            begin
                if (any_req && !item.block_all && (sel ? line_ok[1] : line_ok[0]))
                begin
                    if (cascade_ok && item.cpu_if)
                    begin
                        for (int c = 0; c < NC; c++)
                        begin
                            if (sel == 1'(c))
                            begin
                                if (c != 0 || !icw4_reg[c][1])
                                begin
                                    isr_next[c] = isr_reg[c] | bit_sel;
                                end
                                if (!item.keep_request)
                                begin
                                    irr_next[c] = irr_reg[c] & ~bit_sel;
                                end
                                result.vector = (vbase_reg[c] & cic_pkg::VECTOR_BASE_MASK)
                                                | {5'd0, line};
                            end
                        end
                        if (sel)
                        begin
                            isr_next[0][cic_pkg::CASCADE_LINE] = 1'b1;
                        end
                        result.taken      = 1'b1;
                        result.taken_line = {sel, line};
                    end
                    else
                    begin
                        result.irq_deferred = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NC; c++)
            begin
                phase_reg[c] <= cic_pkg::PH_READY;
                irr_reg[c]   <= 8'h00;
                isr_reg[c]   <= 8'h00;
                lps_reg[c]   <= 3'd0;
                ocw3_reg[c]  <= cic_pkg::OCW3_RESET;
                icw1_reg[c]  <= 8'h00;
                icw3_reg[c]  <= 8'h00;
                icw4_reg[c]  <= 8'h00;
            end
            mask_reg[0]  <= cic_pkg::MASK_RESET_MASTER;
            mask_reg[1]  <= cic_pkg::MASK_RESET_SLAVE;
            vbase_reg[0] <= cic_pkg::VECTOR_RESET_MASTER;
            vbase_reg[1] <= cic_pkg::VECTOR_RESET_SLAVE;
        end
        else if (fire)
        begin
            for (int c = 0; c < NC; c++)
            begin
                phase_reg[c] <= phase_next[c];
                mask_reg[c]  <= mask_next[c];
                vbase_reg[c] <= vbase_next[c];
                irr_reg[c]   <= irr_next[c];
                isr_reg[c]   <= isr_next[c];
                lps_reg[c]   <= lps_next[c];
                ocw3_reg[c]  <= ocw3_next[c];
                icw1_reg[c]  <= icw1_next[c];
                icw3_reg[c]  <= icw3_next[c];
                icw4_reg[c]  <= icw4_next[c];
            end
        end
    end

endmodule

[src/cic_out_stage.sv]
// ----------------------------------------------------------------------------
// cic_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module cic_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  cic_pkg::result_t result_in,
    output logic             can_load,
    output logic             result_valid,
    input  logic             result_stall,
    output cic_pkg::result_t result_out
);

    logic             valid_reg;
    cic_pkg::result_t result_reg;

    assign can_load     = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign result_out   = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_in;
        end
    end

endmodule

[src/cascaded_interrupt_controller_core.sv]
// ----------------------------------------------------------------------------
// cascaded_interrupt_controller_core
// Master/slave pair of 8259-style interrupt controllers, one action per beat.
// ----------------------------------------------------------------------------
// Each beat carries one action (port write, port read, raise or lower an IRQ
// line, or a check) and yields exactly one result beat. The block accepts one
// beat every cycle unless item_stall is high; a result is presented after its
// beat passes the input register and then the result register. The single
// pass between the two registers is the rotating priority search over IRR and
// ISR of both chips followed by the state update. A stalled result holds in
// the result register; an empty input register takes one more beat, and the
// input then stalls until the result is taken.
module cascaded_interrupt_controller_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [2:0] action,
    input  logic [1:0] port_index,
    input  logic [7:0] write_data,
    input  logic [3:0] irq_line,
    input  logic       cpu_if,
    input  logic       block_all,
    input  logic       keep_request,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] read_data,
    output logic       taken,
    output logic [7:0] vector,
    output logic [3:0] taken_line,
    output logic       irq_deferred
);

    cic_pkg::item_t   item_in;
    cic_pkg::item_t   item_cur;
    cic_pkg::result_t result_cur;
    cic_pkg::result_t result_out;
    logic             can_load;
    logic             fire;

    assign item_in.action       = action;
    assign item_in.port_index   = port_index;
    assign item_in.write_data   = write_data;
    assign item_in.irq_line     = irq_line;
    assign item_in.cpu_if       = cpu_if;
    assign item_in.block_all    = block_all;
    assign item_in.keep_request = keep_request;

    cic_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_in    (item_in),
        .can_load   (can_load),
        .fire       (fire),
        .item_out   (item_cur)
    );

    cic_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_cur),
        .result (result_cur)
    );

    cic_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .result_in    (result_cur),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_out   (result_out)
    );

    assign read_data    = result_out.read_data;
    assign taken        = result_out.taken;
    assign vector       = result_out.vector;
    assign taken_line   = result_out.taken_line;
    assign irq_deferred = result_out.irq_deferred;

endmodule

[src/cic_checker.sv]
// ----------------------------------------------------------------------------
// cic_checker
// Port-level checks on result beats of the cascaded interrupt controller.
// ----------------------------------------------------------------------------
module cic_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] read_data,
    input logic       taken,
    input logic [7:0] vector,
    input logic [3:0] taken_line,
    input logic       irq_deferred
);

    a_taken_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(taken && irq_deferred) && !(taken && read_data != 8'h00))
        else $error("taken together with another answer");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !taken) |-> (vector == 8'h00 && taken_line == 4'h0))
        else $error("vector or line without delivery");

    a_vector_line: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && taken) |-> (vector[2:0] == taken_line[2:0]))
        else $error("vector does not match delivered line");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(taken)
                                            && $stable(read_data)))
        else $error("stalled result beat changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled without a stalled result");

endmodule

bind cascaded_interrupt_controller_core cic_checker u_cic_checker (.*);
